[rtl/assert_macros.svh]
// Assertion macros used by the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

[rtl/fpsa_pkg.sv]
// Shared constants and types of the free page stack allocator.
package fpsa_pkg;

   // Geometry of the managed memory
   localparam int MAX_PAGES  = 4096;
   localparam int PAGE_BYTES = 4096;
   localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
   localparam int PAGE_W     = $clog2(MAX_PAGES);
   localparam int COUNT_W    = $clog2(MAX_PAGES + 1);
   localparam int ADDR_BITS  = 64;

   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_PAGES);

   // Queue depths between the stages
   localparam int CMD_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 2;

   // Operation codes
   localparam logic FUNC_ADD   = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // Result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_EMPTY    = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   // Register map
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_LOW_PAGE = 1'b0;

   // Classified command: page range [lo, hi) for an add
   typedef struct packed {
      logic               func;
      logic [COUNT_W-1:0] lo;
      logic [COUNT_W-1:0] hi;
   } cmd_type;

   // One result item
   typedef struct packed {
      logic [PAGE_W-1:0]  page;
      logic [1:0]         status;
      logic [COUNT_W-1:0] free_count;
      logic [COUNT_W-1:0] page_limit;
   } rsp_type;

endpackage

[rtl/free_page_stack_allocator.sv]
// Free page stack allocator: top level with register port, front end and back end.
//
// Physical page allocator with a stack of up to 4096 free page numbers and a
// presence bit per page. After reset the presence map is swept to zero, one
// page per cycle; req_full stays high meanwhile while the low_page register
// can still be written. Requests enter a two-entry command queue, one per
// cycle while req_full is low, where regions are turned into clamped page ranges.
// The executor runs one command at a time: an allocate reads the stack RAM,
// then clears the presence bit, or returns an empty status when the stack is
// empty; an add checks each page with a presence map read step and a check
// step, takes one more step to jump past pages below low_page, and ends in the
// check step if the stack is full. Results wait in a two-entry queue, so the
// executor keeps working while a result is pending.
module free_page_stack_allocator (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_push,
   output logic                               req_full,
   input  logic                               req_func,
   input  logic [63:0]                        req_region_base,
   input  logic [63:0]                        req_region_length,
   // Result channel
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [fpsa_pkg::PAGE_W-1:0]        rsp_page,
   output logic [1:0]                         rsp_status,
   output logic [fpsa_pkg::COUNT_W-1:0]       rsp_free_count,
   output logic [fpsa_pkg::COUNT_W-1:0]       rsp_page_limit,
   // Register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fpsa_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import fpsa_pkg::*;
   `include "assert_macros.svh"

   logic [COUNT_W-1:0] low_page_ff, low_page_in;
   logic               csr_wr;
   logic               clearing;
   logic               cmd_valid;
   logic               cmd_pop;
   cmd_type            cmd;
   rsp_type            rsp;
   logic               shown_empty;
   logic               shown_ovf;
   logic               rsp_none;
   logic               rsp_at_max;
   logic               rsp_over_max;

   // Register write and read
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      low_page_in = low_page_ff;
      if (csr_wr && (csr_paddr[2] == REG_LOW_PAGE)) begin
         low_page_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_page_ff <= '0;
      end else begin
         low_page_ff <= low_page_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_LOW_PAGE) ? 32'(low_page_ff) : 32'd0;

   fpsa_front u_front (
      .clock         (clock),
      .reset         (reset),
      .hold          (clearing),
      .push          (req_push),
      .full          (req_full),
      .func          (req_func),
      .region_base   (req_region_base),
      .region_length (req_region_length),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   fpsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .low_page  (low_page_ff),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .clearing  (clearing),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_page       = rsp.page;
   assign rsp_status     = rsp.status;
   assign rsp_free_count = rsp.free_count;
   assign rsp_page_limit = rsp.page_limit;

   // Consistency checks
   assign shown_empty  = !rsp_empty && (rsp_status == ST_EMPTY);
   assign shown_ovf    = !rsp_empty && (rsp_status == ST_OVERFLOW);
   assign rsp_none     = (rsp_page == '0) && (rsp_free_count == '0);
   assign rsp_at_max   = (rsp_free_count == MAX_COUNT);
   assign rsp_over_max = !rsp_empty && (rsp_free_count > MAX_COUNT);

   `ASSERT_CLK(a_clear_blocks, clock, reset, clearing |-> req_full, "request taken during clear")
   `ASSERT_CLK(a_empty_result, clock, reset, shown_empty |-> rsp_none, "empty result not clean")
   `ASSERT_CLK(a_overflow_full, clock, reset, shown_ovf |-> rsp_at_max, "overflow below full")
   `ASSERT_NEVER(a_count_range, clock, reset, rsp_over_max, "free count out of range")

endmodule

[rtl/fpsa_ram.sv]
// Generic simple dual-port RAM with registered read data.
module fpsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/fpsa_front.sv]
// Front end: accepts request transfers, turns regions into page ranges, queues commands.
module fpsa_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   hold,
   input  logic                   push,
   output logic                   full,
   input  logic                   func,
   input  logic [63:0]            region_base,
   input  logic [63:0]            region_length,
   output logic                   cmd_valid,
   output fpsa_pkg::cmd_type      cmd,
   input  logic                   cmd_pop
);
   import fpsa_pkg::*;

   localparam int HI_W  = ADDR_BITS - PAGE_SHIFT;
   localparam int PTR_W = $clog2(CMD_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

   logic [PAGE_SHIFT-1:0] odd;
   logic                  odd_nz;
   logic [PAGE_SHIFT:0]   gap;
   logic                  is_short;
   logic [63:0]           len_adj;
   logic [HI_W:0]         first_adj;
   logic                  in_range;
   logic [HI_W-1:0]       npages;
   logic [COUNT_W-1:0]    n_sat;
   logic [COUNT_W-1:0]    lo;
   logic [COUNT_W:0]      sum;
   logic [COUNT_W-1:0]    hi;
   cmd_type               entry;
   logic                  accept;

   cmd_type           q_ff [CMD_QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Round the base up to a page boundary and trim the length to match
   always_comb begin
      odd       = region_base[PAGE_SHIFT-1:0];
      odd_nz    = |odd;
      gap       = (PAGE_SHIFT + 1)'(PAGE_BYTES) - {1'b0, odd};
      is_short  = odd_nz && (region_length < 64'(gap));
      len_adj   = odd_nz ? (region_length - 64'(gap)) : region_length;
      first_adj = {1'b0, region_base[63:PAGE_SHIFT]} + (HI_W + 1)'(odd_nz);
      in_range  = first_adj < (HI_W + 1)'(MAX_PAGES);
      npages    = len_adj[63:PAGE_SHIFT];
   end

   // Clamp the page range to the managed pages
   always_comb begin
      n_sat = (npages >= HI_W'(MAX_PAGES)) ? MAX_COUNT : npages[COUNT_W-1:0];
      lo    = (is_short || !in_range) ? MAX_COUNT : first_adj[COUNT_W-1:0];
      sum   = {1'b0, lo} + {1'b0, n_sat};
      hi    = (sum > {1'b0, MAX_COUNT}) ? MAX_COUNT : sum[COUNT_W-1:0];
      entry.func = func;
      entry.lo   = lo;
      entry.hi   = hi;
   end

   // Command queue control
   assign full      = hold || (cnt_ff == CNT_W'(CMD_QUEUE_DEPTH));
   assign accept    = push && !full;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rd_ff];

   always_comb begin
      wr_in  = accept ? wr_ff + 1'b1 : wr_ff;
      rd_in  = (cmd_pop && cmd_valid) ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + CNT_W'(accept) - CNT_W'(cmd_pop && cmd_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the classified command
   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ff] <= entry;
      end
   end

endmodule

[rtl/fpsa_back.sv]
// Back end: executes commands against the free stack and presence map, queues results.
module fpsa_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [fpsa_pkg::COUNT_W-1:0]  low_page,
   input  logic                          cmd_valid,
   input  fpsa_pkg::cmd_type             cmd,
   output logic                          cmd_pop,
   output logic                          clearing,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output fpsa_pkg::rsp_type             rsp
);
   import fpsa_pkg::*;

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CLEAR,
      IDLE,
      ALLOC_RD,
      ADD_RD,
      ADD_CHK
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] hw_ff, hw_in;
   logic [COUNT_W-1:0] pg_ff, pg_in;
   logic [COUNT_W-1:0] hi_ff, hi_in;
   logic [PAGE_W-1:0]  clr_ff, clr_in;

   logic               stk_we, stk_re;
   logic [PAGE_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;
   logic               prs_we, prs_re;
   logic [PAGE_W-1:0]  prs_waddr, prs_raddr;
   logic               prs_wdata, prs_rdata;

   logic               res_push;
   rsp_type            res;
   logic [COUNT_W-1:0] end_now;
   logic [COUNT_W-1:0] count_dec;

   rsp_type            rq_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0]   rq_wr_ff, rq_wr_in;
   logic [PTR_W-1:0]   rq_rd_ff, rq_rd_in;
   logic [CNT_W-1:0]   rq_cnt_ff, rq_cnt_in;
   logic               rq_full;
   logic               rq_take;

   // Stack of free page numbers
   fpsa_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // One presence bit per page
   fpsa_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_present (
      .clock (clock),
      .we    (prs_we),
      .waddr (prs_waddr),
      .wdata (prs_wdata),
      .re    (prs_re),
      .raddr (prs_raddr),
      .rdata (prs_rdata)
   );

   assign end_now   = (hw_ff > low_page) ? hw_ff : low_page;
   assign count_dec = count_ff - 1'b1;
   assign clearing  = (state_ff == CLEAR);

   // Sequence one command at a time
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      hw_in          = hw_ff;
      pg_in          = pg_ff;
      hi_in          = hi_ff;
      clr_in         = clr_ff;
      cmd_pop        = 1'b0;
      stk_we         = 1'b0;
      stk_re         = 1'b0;
      stk_waddr      = count_ff[PAGE_W-1:0];
      stk_wdata      = pg_ff[PAGE_W-1:0];
      stk_raddr      = count_dec[PAGE_W-1:0];
      prs_we         = 1'b0;
      prs_re         = 1'b0;
      prs_waddr      = pg_ff[PAGE_W-1:0];
      prs_wdata      = 1'b0;
      prs_raddr      = pg_ff[PAGE_W-1:0];
      res_push       = 1'b0;
      res.page       = '0;
      res.status     = ST_OK;
      res.free_count = count_ff;
      res.page_limit = end_now;
      unique case (state_ff)
         CLEAR: begin
            // Sweep the presence map to zero
            prs_we    = 1'b1;
            prs_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = IDLE;
            end
         end
         IDLE: begin
            if (cmd_valid && !rq_full) begin
               cmd_pop = 1'b1;
               if (cmd.func == FUNC_ALLOC) begin
                  if (count_ff == '0) begin
                     res_push   = 1'b1;
                     res.status = ST_EMPTY;
                  end else begin
                     stk_re   = 1'b1;
                     count_in = count_dec;
                     state_in = ALLOC_RD;
                  end
               end else begin
                  pg_in    = cmd.lo;
                  hi_in    = cmd.hi;
                  state_in = ADD_RD;
               end
            end
         end
         ALLOC_RD: begin
            // Pop lands: drop the page from the presence map
            prs_we    = 1'b1;
            prs_waddr = stk_rdata;
            res_push  = 1'b1;
            res.page  = stk_rdata;
            state_in  = IDLE;
         end
         ADD_RD: begin
            priority if (pg_ff >= hi_ff) begin
               res_push = 1'b1;
               state_in = IDLE;
            end else if (pg_ff < low_page) begin
               // Jump over the unmanaged low pages
               pg_in = low_page;
            end else begin
               prs_re   = 1'b1;
               state_in = ADD_CHK;
            end
         end
         ADD_CHK: begin
            priority if (prs_rdata) begin
               pg_in    = pg_ff + 1'b1;
               state_in = ADD_RD;
            end else if (count_ff == MAX_COUNT) begin
               res_push   = 1'b1;
               res.status = ST_OVERFLOW;
               state_in   = IDLE;
            end else begin
               stk_we    = 1'b1;
               prs_we    = 1'b1;
               prs_wdata = 1'b1;
               count_in  = count_ff + 1'b1;
               if (pg_ff >= hw_ff) begin
                  hw_in = pg_ff + 1'b1;
               end
               pg_in    = pg_ff + 1'b1;
               state_in = ADD_RD;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         count_ff <= '0;
         hw_ff    <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hw_ff    <= hw_in;
         clr_ff   <= clr_in;
      end
      pg_ff <= pg_in;
      hi_ff <= hi_in;
   end

   // Result queue control
   assign rq_full   = (rq_cnt_ff == CNT_W'(RSP_QUEUE_DEPTH));
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rq_take   = rsp_pop && !rsp_empty;
   assign rsp       = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in  = res_push ? rq_wr_ff + 1'b1 : rq_wr_ff;
      rq_rd_in  = rq_take ? rq_rd_ff + 1'b1 : rq_rd_ff;
      rq_cnt_in = rq_cnt_ff + CNT_W'(res_push) - CNT_W'(rq_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   // Store the finished result
   always_ff @(posedge clock) begin
      if (res_push) begin
         rq_ff[rq_wr_ff] <= res;
      end
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the free page stack allocator: directed rows, random phases, then a full stack.
module tb_top;
   import fpsa_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int TAIL_CYCLES     = 64;
   localparam int HOLD_CYCLES     = 300;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 185;
   localparam logic [CSR_ADDR_W-1:0] LOW_PAGE_ADDR = {REG_LOW_PAGE, 2'b00};
   localparam logic [63:0] ALL_ONES   = '1;
   localparam logic [63:0] WHOLE_SPAN = 64'(MAX_PAGES) * 64'(PAGE_BYTES);

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_LOW_PAGE
   } row_kind_type;

   // One directed row: an item to offer, or a low_page value carried in base
   typedef struct packed {
      row_kind_type kind;
      logic         func;
      logic [63:0]  base;
      logic [63:0]  len;
      logic         typed;
      rsp_type      want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_push          = 1'b0;
   logic                  req_full;
   logic                  req_func          = FUNC_ALLOC;
   logic [63:0]           req_region_base   = '0;
   logic [63:0]           req_region_length = '0;
   logic                  rsp_empty;
   logic                  rsp_pop           = 1'b0;
   logic [PAGE_W-1:0]     rsp_page;
   logic [1:0]            rsp_status;
   logic [COUNT_W-1:0]    rsp_free_count;
   logic [COUNT_W-1:0]    rsp_page_limit;
   logic                  csr_psel          = 1'b0;
   logic                  csr_penable       = 1'b0;
   logic                  csr_pwrite        = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr         = '0;
   logic [31:0]           csr_pwdata        = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   // Predicted allocator state
   logic [PAGE_W-1:0]  free_pages [MAX_PAGES];
   bit                 on_stack [MAX_PAGES];
   logic [COUNT_W-1:0] depth         = '0;
   logic [COUNT_W-1:0] top_mark      = '0;
   logic [COUNT_W-1:0] first_managed = '0;

   rsp_type      pending_rsp [$];
   plan_row_type plan [$];
   int           errors       = 0;
   int           cycle_count  = 0;
   bit           steady       = 1'b0;
   bit           hold_request = 1'b0;

   free_page_stack_allocator uut (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_func          (req_func),
      .req_region_base   (req_region_base),
      .req_region_length (req_region_length),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_page          (rsp_page),
      .rsp_status        (rsp_status),
      .rsp_free_count    (rsp_free_count),
      .rsp_page_limit    (rsp_page_limit),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #HALF_PERIOD clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("free_page_stack_allocator: mismatch");
         $finish;
      end
   end

   // Push every whole, managed page of a byte region not yet on the predicted stack
   function automatic logic [1:0] add_region(input logic [63:0] base, input logic [63:0] len);
      logic [63:0] first;
      logic [63:0] last;
      logic [63:0] span;
      logic [63:0] gap;
      logic [63:0] pg;
      first = base >> PAGE_SHIFT;
      span  = len;
      if (base[PAGE_SHIFT-1:0] != '0) begin
         gap = 64'(PAGE_BYTES) - 64'(base[PAGE_SHIFT-1:0]);
         if (span < gap)
            return ST_OK;
         first = first + 64'd1;
         span  = span - gap;
      end
      last = first + (span >> PAGE_SHIFT);
      if (last > 64'(MAX_PAGES))
         last = 64'(MAX_PAGES);
      for (pg = first; pg < last; pg++) begin
         if (pg < 64'(first_managed) || on_stack[pg[PAGE_W-1:0]])
            continue;
         if (depth >= MAX_COUNT)
            return ST_OVERFLOW;
         free_pages[depth[PAGE_W-1:0]] = pg[PAGE_W-1:0];
         depth = depth + 1'b1;
         on_stack[pg[PAGE_W-1:0]] = 1'b1;
         if (pg >= 64'(top_mark))
            top_mark = COUNT_W'(pg + 64'd1);
      end
      return ST_OK;
   endfunction

   // Advance the predicted state by one item and return its result
   function automatic rsp_type predict_page_op(input logic func, input logic [63:0] base,
                                               input logic [63:0] len);
      rsp_type r;
      r.page   = '0;
      r.status = ST_OK;
      if (func == FUNC_ADD) begin
         r.status = add_region(base, len);
      end else if (depth == '0) begin
         r.status = ST_EMPTY;
      end else begin
         depth           = depth - 1'b1;
         r.page          = free_pages[depth[PAGE_W-1:0]];
         on_stack[r.page] = 1'b0;
      end
      r.free_count = depth;
      r.page_limit = (top_mark > first_managed) ? top_mark : first_managed;
      return r;
   endfunction

   function automatic int draw_gap();
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void plan_row(input row_kind_type kind, input logic func,
                                    input logic [63:0] base, input logic [63:0] len,
                                    input logic typed, input logic [PAGE_W-1:0] page,
                                    input logic [1:0] status, input logic [COUNT_W-1:0] count,
                                    input logic [COUNT_W-1:0] end_pg);
      plan_row_type row;
      row.kind            = kind;
      row.func            = func;
      row.base            = base;
      row.len             = len;
      row.typed           = typed;
      row.want.page       = page;
      row.want.status     = status;
      row.want.free_count = count;
      row.want.page_limit = end_pg;
      plan.push_back(row);
   endfunction

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      rsp_type want;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected result page %0d status %0d count %0d end %0d",
                  $time, rsp_page, rsp_status, rsp_free_count, rsp_page_limit);
         errors++;
      end else begin
         want = pending_rsp.pop_front();
         compare_field("page", 32'(want.page), 32'(rsp_page));
         compare_field("status", 32'(want.status), 32'(rsp_status));
         compare_field("free_count", 32'(want.free_count), 32'(rsp_free_count));
         compare_field("page_limit", 32'(want.page_limit), 32'(rsp_page_limit));
      end
   endtask

   // Hold one item on the request port until its transfer, then maybe idle
   task automatic offer_item(input logic func, input logic [63:0] base, input logic [63:0] len,
                             input logic typed, input rsp_type want);
      rsp_type predicted;
      int gap;
      req_push          <= 1'b1;
      req_func          <= func;
      req_region_base   <= base;
      req_region_length <= len;
      do @(posedge clock); while (req_full !== 1'b0);
      predicted = predict_page_op(func, base, len);
      pending_rsp.push_back(typed ? want : predicted);
      gap = draw_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop push and wait until every expected result has been taken
   task automatic drain_results();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // Write low_page with a setup and an access phase, then read it back
   task automatic set_low_page(input logic [COUNT_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= LOW_PAGE_ADDR;
      csr_pwdata  <= 32'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      first_managed = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      compare_field("low_page", 32'(first_managed), {19'd0, csr_prdata[COUNT_W-1:0]});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // Result side: take transfers, idle at random, and hold off on request
   initial begin : result_sink
      int idle_left;
      int hold_left;
      idle_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && rsp_empty === 1'b0)
            check_result();
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop   <= 1'b1;
            idle_left = draw_gap();
         end
      end
   end

   initial begin : stimulus
      int          phase;
      int          n;
      int          roll;
      int          add_share;
      int          npg;
      logic        func;
      logic [63:0] base;
      logic [63:0] len;
      rsp_type     none;
      none = '0;

      // Directed rows; low_page starts at zero
      plan_row(ROW_ITEM, FUNC_ALLOC, 64'd0, 64'd0, 1'b1, '0, ST_EMPTY, 13'd0, 13'd0);
      plan_row(ROW_ITEM, FUNC_ADD, 64'd0, 64'd0, 1'b1, '0, ST_OK, 13'd0, 13'd0);
      // short unaligned region adds nothing
      plan_row(ROW_ITEM, FUNC_ADD, 64'd1, 64'd4094, 1'b1, '0, ST_OK, 13'd0, 13'd0);
      // unaligned start rounded up to page one
      plan_row(ROW_ITEM, FUNC_ADD, 64'd4095, 64'd4097, 1'b1, '0, ST_OK, 13'd1, 13'd2);
      // page one already on the stack is skipped
      plan_row(ROW_ITEM, FUNC_ADD, 64'd0, 64'd3 * 64'd4096, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ALLOC, ALL_ONES, ALL_ONES, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_LOW_PAGE, FUNC_ADD, 64'd10, 64'd0, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ALLOC, 64'd0, 64'd0, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ADD, 64'd0, 64'd20 * 64'd4096, 1'b0, '0, ST_OK, '0, '0);
      // last page kept, the one past the end dropped
      plan_row(ROW_ITEM, FUNC_ADD, 64'hFFF000, 64'd2 * 64'd4096, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ADD, 64'hFFFF_FFFF_FFFF_F000, ALL_ONES, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ADD, ALL_ONES, 64'd0, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ADD, WHOLE_SPAN, 64'd4096, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ALLOC, 64'd0, 64'd0, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_LOW_PAGE, FUNC_ADD, 64'(MAX_PAGES), 64'd0, 1'b0, '0, ST_OK, '0, '0);
      // every page below low_page counts as present
      plan_row(ROW_ITEM, FUNC_ADD, 64'd0, WHOLE_SPAN, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ALLOC, 64'd0, 64'd0, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_LOW_PAGE, FUNC_ADD, 64'd0, 64'd0, 1'b0, '0, ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ADD, 64'd5 * 64'd4096 + 64'd7, 64'd3 * 64'd4096, 1'b0, '0,
               ST_OK, '0, '0);
      plan_row(ROW_ITEM, FUNC_ALLOC, 64'd0, 64'd0, 1'b0, '0, ST_OK, '0, '0);

      // Hold reset, then write the register while the presence map is cleared
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      set_low_page('0);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_LOW_PAGE) begin
            drain_results();
            set_low_page(plan[i].base[COUNT_W-1:0]);
         end else begin
            offer_item(plan[i].func, plan[i].base, plan[i].len, plan[i].typed, plan[i].want);
         end
      end

      // Random phases: 35 and 10 percent adds in turn, each under a newly written low_page
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         unique case (phase)
            0: set_low_page(13'd1);
            1: set_low_page(13'(MAX_PAGES));
            3: set_low_page(13'd0);
            5: set_low_page(13'd0);
            default: set_low_page(13'($urandom_range(0, MAX_PAGES)));
         endcase
         steady = (phase == 3);
         if (phase == 2)
            hold_request = 1'b1;
         add_share = (phase % 2 == 0) ? 35 : 10;
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            base = {$urandom, $urandom};
            len  = {$urandom, $urandom};
            if ($urandom_range(0, 99) < add_share) begin
               func = FUNC_ADD;
               roll = $urandom_range(0, 99);
               // most adds are small regions near the managed pages; the rest stay random
               if (roll >= 10) begin
                  base = 64'($urandom_range(0, MAX_PAGES + 104)) << PAGE_SHIFT;
                  if ($urandom_range(0, 2) == 0)
                     base[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
                  npg = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64)
                                                    : $urandom_range(0, 6);
                  len = 64'(npg) << PAGE_SHIFT;
                  if ($urandom_range(0, 2) == 0)
                     len[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
               end
            end else begin
               func = FUNC_ALLOC;
            end
            offer_item(func, base, len, 1'b0, none);
         end
      end
      steady = 1'b0;

      // Fill the stack with the whole memory, then show a full stack takes no more
      offer_item(FUNC_ADD, 64'd0, WHOLE_SPAN, 1'b0, none);
      offer_item(FUNC_ADD, 64'd0, ALL_ONES, 1'b0, none);
      offer_item(FUNC_ALLOC, ALL_ONES, ALL_ONES, 1'b0, none);
      offer_item(FUNC_ADD, 64'd0, WHOLE_SPAN, 1'b0, none);
      offer_item(FUNC_ALLOC, 64'd0, 64'd0, 1'b0, none);

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("free_page_stack_allocator: match");
      else
         $display("free_page_stack_allocator: mismatch");
      $finish;
   end

endmodule

[free_page_stack_allocator.f]
+incdir+rtl
rtl/fpsa_pkg.sv
rtl/fpsa_ram.sv
rtl/fpsa_front.sv
rtl/fpsa_back.sv
rtl/free_page_stack_allocator.sv
bench/tb_top.sv
